FILE: hw/rtl/rtu_pkg.sv
// -----------------------------------------------------------------------------
// rtu_pkg
// Shared types for the RGB to UYVY 4:2:2 packer: the request and result
// payloads and the converted colour triple passed between stages.
// -----------------------------------------------------------------------------
package rtu_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       line_start;
   } pixel_type;

   typedef struct packed {
      logic [7:0] chroma_byte;
      logic [7:0] luma_byte;
      logic       chroma_is_u;
   } result_type;

   typedef struct packed {
      logic [7:0] y;
      logic [7:0] u;
      logic [7:0] v;
   } ycc_type;

endpackage

FILE: hw/rtl/rtu_convert.sv
// -----------------------------------------------------------------------------
// rtu_convert
// Combinational BT.601 studio-swing conversion of one 8-bit RGB pixel into
// Y, U and V bytes, using rounded unsigned fixed-point coefficients.
// -----------------------------------------------------------------------------
module rtu_convert #(
   parameter int COEF_FRAC_BITS = 16
) (
   input  rtu_pkg::pixel_type pixel,
   output rtu_pkg::ycc_type   ycc
);
   import rtu_pkg::*;

   localparam int W = COEF_FRAC_BITS + 10;

   localparam logic [W-1:0] K257 = W'(((64'd257 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [W-1:0] K504 = W'(((64'd504 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [W-1:0] K098 = W'(((64'd98 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [W-1:0] K148 = W'(((64'd148 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [W-1:0] K291 = W'(((64'd291 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [W-1:0] K368 = W'(((64'd368 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [W-1:0] K071 = W'(((64'd71 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [W-1:0] KUB  = K148 + K291;
   localparam logic [W-1:0] KVR  = K368 + K071;
   localparam logic [W-1:0] OFS16  = W'(64'd16 << COEF_FRAC_BITS);
   localparam logic [W-1:0] OFS128 = W'(64'd128 << COEF_FRAC_BITS);

   logic [W-1:0] r_ext;
   logic [W-1:0] g_ext;
   logic [W-1:0] b_ext;
   logic [W-1:0] y_pos;
   logic [W-1:0] u_pos;
   logic [W-1:0] u_neg;
   logic [W-1:0] v_pos;
   logic [W-1:0] v_neg;

   function automatic logic [7:0] to_byte(input logic [W-1:0] pos, input logic [W-1:0] neg);
      logic [W-1:0] diff;
      logic [7:0]   res;
      diff = pos - neg;
      if (neg > pos) begin
         res = 8'd0;
      end else if (|diff[W-1:COEF_FRAC_BITS+8]) begin
         res = 8'hFF;
      end else begin
         res = diff[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
      end
      return res;
   endfunction

   assign r_ext = W'(pixel.red);
   assign g_ext = W'(pixel.green);
   assign b_ext = W'(pixel.blue);

   assign y_pos = K257 * r_ext + K504 * g_ext + K098 * b_ext + OFS16;
   assign u_pos = KUB * b_ext + OFS128;
   assign u_neg = K148 * r_ext + K291 * g_ext;
   assign v_pos = KVR * r_ext + OFS128;
   assign v_neg = K368 * g_ext + K071 * b_ext;

   assign ycc.y = to_byte(y_pos, '0);
   assign ycc.u = to_byte(u_pos, u_neg);
   assign ycc.v = to_byte(v_pos, v_neg);

endmodule

FILE: hw/rtl/rtu_pack.sv
// -----------------------------------------------------------------------------
// rtu_pack
// UYVY packing stage: tracks pixel parity, holds the even pixel's V for the
// following odd pixel and drives the registered result channel.
// -----------------------------------------------------------------------------
module rtu_pack (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  rtu_pkg::ycc_type    ycc,
   input  logic                line_start,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output rtu_pkg::result_type rsp_result
);
   import rtu_pkg::*;

   logic       odd_pixel_ff;
   logic       odd_pixel_in;
   logic [7:0] held_v_ff;
   logic [7:0] held_v_in;
   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;
   result_type result_in;
   logic       even;

   always_comb begin
      even         = line_start | ~odd_pixel_ff;
      odd_pixel_in = odd_pixel_ff;
      held_v_in    = held_v_ff;
      result_in    = result_ff;
      valid_in     = valid_ff & rsp_stall;
      if (advance) begin
         valid_in             = 1'b1;
         result_in.luma_byte  = ycc.y;
         result_in.chroma_is_u = even;
         odd_pixel_in         = even;
         if (even) begin
            result_in.chroma_byte = ycc.u;
            held_v_in             = ycc.v;
         end else begin
            result_in.chroma_byte = held_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         odd_pixel_ff <= 1'b0;
         held_v_ff    <= 8'd0;
         valid_ff     <= 1'b0;
      end else begin
         odd_pixel_ff <= odd_pixel_in;
         held_v_ff    <= held_v_in;
         valid_ff     <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

FILE: hw/rtl/rgb_to_uyvy_packer_core.sv
// -----------------------------------------------------------------------------
// rgb_to_uyvy_packer_core
// BT.601 RGB to UYVY 4:2:2 packer, one pixel per request.
//
// A request on the req_ channel carries one 8-bit RGB pixel and a line-start
// flag; each request yields exactly one result on the rsp_ channel holding a
// chroma byte, the pixel's luma byte and a flag telling U from V. Even pixels
// send their own U and keep their V; odd pixels send the kept V.
// The request is captured in an input register, converted by combinational
// logic and written to the result register, which drives the rsp_ channel.
// One request is taken every cycle while the receiver keeps taking results;
// the multiply-add path of the conversion stage sets the clock limit.
// Reset empties both registers, clears the held V to zero and makes the next
// pixel even. While the receiver stalls, the result holds, the input register
// fills and req_stall rises only once both registers are occupied.
// -----------------------------------------------------------------------------
module rgb_to_uyvy_packer_core #(
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rtu_pkg::pixel_type  req_pixel,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rtu_pkg::result_type rsp_result
);
   import rtu_pkg::*;

   logic      s1_valid_ff;
   logic      s1_valid_in;
   pixel_type s1_pixel_ff;
   pixel_type s1_pixel_in;
   logic      accept;
   logic      advance;
   ycc_type   ycc;

   assign advance   = s1_valid_ff & ~(rsp_valid & rsp_stall);
   assign req_stall = s1_valid_ff & rsp_valid & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      s1_valid_in = accept | (s1_valid_ff & ~advance);
      s1_pixel_in = accept ? req_pixel : s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_pixel_ff <= s1_pixel_in;
   end

   rtu_convert #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_convert (
      .pixel(s1_pixel_ff),
      .ycc  (ycc)
   );

   rtu_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ycc       (ycc),
      .line_start(s1_pixel_ff.line_start),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_result(rsp_result)
   );

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid && rsp_stall))
      else $error("request stalled while a stage was free");

   a_input_moves_on: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !(rsp_valid && rsp_stall)) |=> rsp_valid)
      else $error("advancing request produced no result");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !s1_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule
